// ===== rtl/codebook_section_run_encoder_defines.svh =====
// assertion macros for the codebook section run encoder
`ifndef CODEBOOK_SECTION_RUN_ENCODER_DEFINES_SVH
`define CODEBOOK_SECTION_RUN_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define CSRE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csre assertion failed");
`define CSRE_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("csre forbidden condition seen");
`else
`define CSRE_ASSERT(label, clk, rst_n, prop)
`define CSRE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/csre_pkg.sv =====
// types and constants shared by the section run encoder modules
package csre_pkg;

  localparam int unsigned MaxFields = 4;

  localparam logic [2:0] CbWidth  = 3'd4;
  localparam logic [2:0] LenShort = 3'd3;
  localparam logic [2:0] LenLong  = 3'd5;
  localparam logic [4:0] EscShort = 5'd7;
  localparam logic [4:0] EscLong  = 5'd31;

  typedef struct packed {
    logic [4:0] value;
    logic [2:0] width;
  } field_t;

  // all fields caused by one band, count is 1 to MaxFields
  typedef struct packed {
    field_t [MaxFields-1:0] fields;
    logic [2:0]             count;
  } cmd_t;

endpackage

// ===== rtl/csre_queue.sv =====
// command queue between the classifying front end and the field emitter
module csre_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csre_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output csre_pkg::cmd_t head_cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import csre_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_cmd_o = mem_q[rd_ptr_q];
  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == FullCnt);

endmodule

// ===== rtl/csre_front.sv =====
// front end: takes bands, tracks the run and builds the field list per band
module csre_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           short_window_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [3:0]     codebook_i,
  input  logic           group_end_i,
  input  logic           queue_full_i,
  output logic           push_o,
  output csre_pkg::cmd_t push_cmd_o
);
  import csre_pkg::*;

  logic [4:0] run_len_q, run_len_d;
  logic [3:0] prev_cb_q, prev_cb_d;
  logic       in_group_q;
  logic       accept;
  logic [4:0] esc;
  logic [2:0] len;
  logic [4:0] run;
  logic [2:0] n;
  cmd_t       cmd;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  always_comb begin
    esc       = short_window_i ? EscShort : EscLong;
    len       = short_window_i ? LenShort : LenLong;
    // a run stored under long windows may exceed the short escape
    run       = (run_len_q > esc) ? esc : run_len_q;
    prev_cb_d = prev_cb_q;
    cmd       = '0;
    n         = '0;

    if (!in_group_q) begin
      cmd.fields[n[1:0]].value = {1'b0, codebook_i};
      cmd.fields[n[1:0]].width = CbWidth;
      n         = n + 3'd1;
      run       = 5'd1;
      prev_cb_d = codebook_i;
    end else if (codebook_i != prev_cb_q) begin
      cmd.fields[n[1:0]].value = run;
      cmd.fields[n[1:0]].width = len;
      n = n + 3'd1;
      if (run == esc) begin
        cmd.fields[n[1:0]].value = '0;
        cmd.fields[n[1:0]].width = len;
        n = n + 3'd1;
      end
      cmd.fields[n[1:0]].value = {1'b0, codebook_i};
      cmd.fields[n[1:0]].width = CbWidth;
      n         = n + 3'd1;
      run       = 5'd1;
      prev_cb_d = codebook_i;
    end else if (run == esc) begin
      cmd.fields[n[1:0]].value = run;
      cmd.fields[n[1:0]].width = len;
      n   = n + 3'd1;
      run = 5'd1;
    end else begin
      run = run + 5'd1;
    end

    if (group_end_i) begin
      cmd.fields[n[1:0]].value = run;
      cmd.fields[n[1:0]].width = len;
      n = n + 3'd1;
      if (run == esc) begin
        cmd.fields[n[1:0]].value = '0;
        cmd.fields[n[1:0]].width = len;
        n = n + 3'd1;
      end
    end

    cmd.count = n;
    run_len_d = run;
  end

  assign push_o     = accept && (n != '0);
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q  <= '0;
      prev_cb_q  <= '0;
      in_group_q <= 1'b0;
    end else if (accept) begin
      run_len_q  <= run_len_d;
      prev_cb_q  <= prev_cb_d;
      in_group_q <= !group_end_i;
    end
  end

endmodule

// ===== rtl/csre_back.sv =====
// back end: walks the queued field lists and drives the output register
module csre_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  csre_pkg::cmd_t head_cmd_i,
  input  logic           queue_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [4:0]     field_value_o,
  output logic [2:0]     field_width_o,
  output logic           last_of_run_o
);
  import csre_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [4:0] value_q;
  logic [2:0] width_q;
  logic       last_q;
  logic       advance;
  logic       is_last;

  assign advance = !queue_empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = ({1'b0, idx_q} == (head_cmd_i.count - 3'd1));
  assign pop_o   = advance && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      idx_q       <= is_last ? '0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q <= head_cmd_i.fields[idx_q].value;
      width_q <= head_cmd_i.fields[idx_q].width;
      last_q  <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_value_o = value_q;
  assign field_width_o = width_q;
  assign last_of_run_o = last_q;

endmodule

// ===== rtl/codebook_section_run_encoder.sv =====
// top level of the codebook section run encoder
`include "codebook_section_run_encoder_defines.svh"

// Section data encoder: one 4-bit codebook number per scalefactor band goes in,
// (value, width) bit fields come out, one field per cycle from an output
// register while out_stall_i is low. A band is taken in every cycle while the
// command queue (QueueDepth entries) has room; a band that causes k fields
// keeps the field emitter busy until all k are sent, so the sustained rate is
// one band per cycle for bands that extend a run and lower otherwise, set by
// the single output register. The first field of a band enters the queue at
// the edge that takes it and then passes to the output register. short_window
// is written by cfg_we_i and must only change while no transaction is in flight.
module codebook_section_run_encoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] codebook_i,
  input  logic       group_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] field_value_o,
  output logic [2:0] field_width_o,
  output logic       last_of_run_o
);
  import csre_pkg::*;

  logic short_window_q;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  cmd_t push_cmd;
  cmd_t head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_window_q <= 1'b0;
    end else if (cfg_we_i) begin
      short_window_q <= cfg_wdata_i;
    end
  end

  csre_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .short_window_i (short_window_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .codebook_i     (codebook_i),
    .group_end_i    (group_end_i),
    .queue_full_i   (q_full),
    .push_o         (push),
    .push_cmd_o     (push_cmd)
  );

  csre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  csre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_cmd_i    (head_cmd),
    .queue_empty_i (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .field_value_o (field_value_o),
    .field_width_o (field_width_o),
    .last_of_run_o (last_of_run_o)
  );

  `CSRE_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push && q_full)
  `CSRE_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && q_empty)
  `CSRE_ASSERT(a_width_legal, clk_i, rst_ni, out_valid_o |-> (field_width_o == LenShort || field_width_o == CbWidth || field_width_o == LenLong))
  `CSRE_ASSERT(a_short_len_range, clk_i, rst_ni, (out_valid_o && field_width_o == LenShort) |-> (field_value_o <= EscShort))

endmodule
